/* sv/tfp_pkg.sv */
// Shared types and constants for the texel format packer.
// No dependencies; imported by every module of the block.
package tfp_pkg;

    localparam int unsigned ADDR_W = 3;   // one 32-bit register at byte address 0
    localparam int unsigned DATA_W = 32;
    localparam int unsigned FMT_W  = 4;

    typedef enum logic [FMT_W-1:0] {
        FMT_RGBA32 = 4'd0,
        FMT_RGBA16 = 4'd1,
        FMT_RGB32  = 4'd2,
        FMT_RGB16  = 4'd3,
        FMT_IA16   = 4'd4,
        FMT_IA8    = 4'd5,
        FMT_IA4    = 4'd6,
        FMT_I8     = 4'd7,
        FMT_I4     = 4'd8
    } t_fmt;

    // register index held in paddr[2]
    localparam logic REG_TEXEL_FORMAT = 1'b0;

    // held high nibble for the 4-bit formats
    typedef struct packed {
        logic       waiting;
        logic [3:0] nib;
    } t_nib_state;

endpackage

/* sv/texel_format_packer.sv */
// Texel format packer top level: config registers, input stage, packer, result stage.
// Depends on tfp_pkg, tfp_regs, tfp_pack.
//
// One RGBA8888 pixel per transaction is packed into the format held in texel_format
// (address 0). While the receiver takes results, a pixel is accepted every cycle. The
// input register feeds the single packing stage, and the result register loads from
// it whenever the result register is free or being drained by the receiver. With both
// registers full and the receiver stalled, o_ready drops until the result leaves.
// Every pixel yields one result; byte_count 0 means a nibble was held for pairing or
// an unknown format. A held nibble persists across format writes; other formats clear it.
module texel_format_packer
    import tfp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_red,
    input  logic [7:0]        i_green,
    input  logic [7:0]        i_blue,
    input  logic [7:0]        i_alpha,
    input  logic              i_row_end,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [31:0]       o_out_bytes,
    output logic [2:0]        o_byte_count
);

    logic [FMT_W-1:0] fmt;

    logic       r_s1_valid;
    logic [7:0] r_s1_red, r_s1_green, r_s1_blue, r_s1_alpha;
    logic       r_s1_row_end;

    logic        r_out_valid;
    logic [31:0] r_out_bytes;
    logic [2:0]  r_byte_count;

    t_nib_state  r_nib_state;
    t_nib_state  n_nib_state;
    logic [31:0] n_out_bytes;
    logic [2:0]  n_byte_count;

    logic s1_advance;
    logic in_take;

    tfp_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_fmt   (fmt)
    );

    tfp_pack u_pack (
        .i_fmt        (fmt),
        .i_red        (r_s1_red),
        .i_green      (r_s1_green),
        .i_blue       (r_s1_blue),
        .i_alpha      (r_s1_alpha),
        .i_row_end    (r_s1_row_end),
        .i_nib_state  (r_nib_state),
        .o_out_bytes  (n_out_bytes),
        .o_byte_count (n_byte_count),
        .o_nib_state  (n_nib_state)
    );

    // result register free or being drained this cycle
    assign s1_advance = !r_out_valid || i_ready;
    assign o_ready    = !r_s1_valid || s1_advance;
    assign in_take    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_nib_state <= '0;
        end else begin
            if (o_ready) begin
                r_s1_valid <= i_valid;
            end
            if (s1_advance) begin
                r_out_valid <= r_s1_valid;
            end
            if (r_s1_valid && s1_advance) begin
                r_nib_state <= n_nib_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_red     <= i_red;
            r_s1_green   <= i_green;
            r_s1_blue    <= i_blue;
            r_s1_alpha   <= i_alpha;
            r_s1_row_end <= i_row_end;
        end
        if (r_s1_valid && s1_advance) begin
            r_out_bytes  <= n_out_bytes;
            r_byte_count <= n_byte_count;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_out_bytes  = r_out_bytes;
    assign o_byte_count = r_byte_count;

endmodule

/* sv/tfp_regs.sv */
// APB-style configuration register block: holds texel_format.
// Depends on tfp_pkg.
module tfp_regs
    import tfp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output logic [FMT_W-1:0]  o_fmt
);

    logic [FMT_W-1:0] r_fmt;
    logic             reg_hit;

    assign reg_hit = (paddr[2] == REG_TEXEL_FORMAT);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= FMT_RGBA32;
        end else if (psel && penable && pwrite && reg_hit) begin
            r_fmt <= pwdata[FMT_W-1:0];
        end
    end

    assign prdata = reg_hit ? {{(DATA_W-FMT_W){1'b0}}, r_fmt} : '0;
    assign o_fmt  = r_fmt;

endmodule

/* sv/tfp_pack.sv */
// Combinational packer: intensity, per-format byte packing and nibble pairing.
// Depends on tfp_pkg.
module tfp_pack
    import tfp_pkg::*;
(
    input  logic [FMT_W-1:0] i_fmt,
    input  logic [7:0]       i_red,
    input  logic [7:0]       i_green,
    input  logic [7:0]       i_blue,
    input  logic [7:0]       i_alpha,
    input  logic             i_row_end,
    input  t_nib_state       i_nib_state,
    output logic [31:0]      o_out_bytes,
    output logic [2:0]       o_byte_count,
    output t_nib_state       o_nib_state
);

    logic [15:0] lum_sum;
    logic [7:0]  lum;
    logic [3:0]  nib;
    logic        nibble_fmt;

    // max sum is 65408, so 16 bits suffice
    assign lum_sum = 16'(16'd77 * {8'd0, i_red}) + 16'(16'd150 * {8'd0, i_green})
                   + 16'(16'd29 * {8'd0, i_blue}) + 16'd128;
    assign lum     = lum_sum[15:8];

    always_comb begin
        o_out_bytes  = '0;
        o_byte_count = 3'd0;
        nib          = 4'd0;
        nibble_fmt   = 1'b0;
        o_nib_state  = '0;
        case (t_fmt'(i_fmt))
            FMT_RGBA32: begin
                o_out_bytes  = {i_red, i_green, i_blue, i_alpha};
                o_byte_count = 3'd4;
            end
            FMT_RGB32: begin
                o_out_bytes  = {i_red, i_green, i_blue, 8'hff};
                o_byte_count = 3'd4;
            end
            FMT_RGBA16: begin
                o_out_bytes  = {16'd0, i_red[7:3], i_green[7:3], i_blue[7:3], i_alpha[7]};
                o_byte_count = 3'd2;
            end
            FMT_RGB16: begin
                o_out_bytes  = {16'd0, i_red[7:3], i_green[7:3], i_blue[7:3], 1'b1};
                o_byte_count = 3'd2;
            end
            FMT_IA16: begin
                o_out_bytes  = {16'd0, lum, i_alpha};
                o_byte_count = 3'd2;
            end
            FMT_IA8: begin
                o_out_bytes  = {24'd0, lum[7:4], i_alpha[7:4]};
                o_byte_count = 3'd1;
            end
            FMT_I8: begin
                o_out_bytes  = {24'd0, lum};
                o_byte_count = 3'd1;
            end
            FMT_IA4: begin
                nib        = {lum[7:5], i_alpha[7]};
                nibble_fmt = 1'b1;
            end
            FMT_I4: begin
                nib        = lum[7:4];
                nibble_fmt = 1'b1;
            end
            default: begin
                // unknown format: no bytes, held nibble dropped
            end
        endcase

        if (nibble_fmt) begin
            if (i_nib_state.waiting) begin
                o_out_bytes  = {24'd0, i_nib_state.nib, nib};
                o_byte_count = 3'd1;
            end else if (i_row_end) begin
                // lone nibble at row end, flushed with zero low nibble
                o_out_bytes  = {24'd0, nib, 4'd0};
                o_byte_count = 3'd1;
            end else begin
                o_nib_state.waiting = 1'b1;
                o_nib_state.nib     = nib;
            end
        end
    end

endmodule

/* sv/tfp_checker.sv */
// Port-level checks for texel_format_packer, attached by bind.
// Depends on tfp_pkg.
module tfp_checker
    import tfp_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_out_bytes,
    input logic [2:0]  o_byte_count
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_bytes) && $stable(o_byte_count))
        else $error("result changed while stalled");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_byte_count <= 3'd4)
        else $error("byte count above four");

    // bytes above the valid ones are zero (checked for byte counts 0 to 2)
    a_upper_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_byte_count != 3'd0 || o_out_bytes == 32'd0)
                 && (o_byte_count != 3'd1 || o_out_bytes[31:8] == 24'd0)
                 && (o_byte_count != 3'd2 || o_out_bytes[31:16] == 16'd0))
        else $error("bytes set above the valid count");

    // with the result register empty, the input side never stalls
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled with empty result register");

endmodule

bind texel_format_packer tfp_checker u_tfp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_out_bytes  (o_out_bytes),
    .o_byte_count (o_byte_count)
);
